// ===== src/assert_macros.svh =====
// assertion macros used by the top-level rtl file
// depends on nothing; users provide clk and rst in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/nmea_pkg.sv =====
// types, constants and helper functions for the nmea field extractor
// no dependencies; used by every module of the block
package nmea_pkg;

  localparam int LINE_CAPACITY = 128;
  localparam int CNT_W = $clog2(LINE_CAPACITY);
  localparam int LEN_W = 10;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_MIN_LEN = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN = 1'b1;
  localparam logic [LEN_W-1:0] MIN_LEN_RESET = 10'd50;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 10'd80;
  localparam logic [LEN_W-1:0] HEADER_LEN = 10'd6;

  localparam logic [1:0] HDR_NONE = 2'd0;
  localparam logic [1:0] HDR_RMC  = 2'd1;
  localparam logic [1:0] HDR_GGA  = 2'd2;
  localparam logic [1:0] HDR_BOTH = 2'd3;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_RMC   = 2'd1;
  localparam logic [1:0] KIND_GGA   = 2'd2;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_W      = 8'h57;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [47:0] RMC_TAG = "$GPRMC";
  localparam logic [47:0] GGA_TAG = "$GPGGA";

  localparam int ACC_L_W = 30;
  localparam int ACC_C_W = 27;
  localparam int MOD_W = 16;
  localparam logic [ACC_L_W-1:0] ACC_L_CAP = 30'd999999999;
  localparam logic [ACC_C_W-1:0] ACC_C_CAP = 27'd99999999;
  localparam int COURSE_MOD_I = 36000;
  localparam logic [MOD_W-1:0] COURSE_MOD = 16'd36000;
  localparam logic [MOD_W-1:0] COURSE_SAT = 16'd27999;
  localparam logic [26:0] LAT_CAP = 27'd99999999;
  localparam logic [23:0] CENTI_CAP = 24'd9999999;

  typedef logic [2:0][6:0] pairs_t;

  typedef struct packed {
    logic                 valid;
    logic                 stage;
    logic                 nl;
    logic                 restart;
    logic [4:0]           pos;
    logic [4:0]           fpos;
    logic [1:0]           hdr;
    logic [CNT_W-1:0]     cnt;
    logic [6:0]           cif;
    logic                 neg;
    logic [2:0]           frac;
    logic [ACC_L_W-1:0]   acc_l;
    logic [ACC_C_W-1:0]   acc_c;
    logic [MOD_W-1:0]     acc_m;
    logic [5:0][7:0]      text;
  } snap_t;

  typedef struct packed {
    logic                 time_ok;
    pairs_t               time_pairs;
    logic signed [27:0]   lat;
    logic                 ns;
    logic signed [30:0]   lon;
    logic                 ew;
    logic [23:0]          speed;
    logic [15:0]          course;
    logic                 date_ok;
    pairs_t               date_pairs;
    logic signed [24:0]   alt;
  } pend_t;

  typedef struct packed {
    logic                 valid;
    logic                 nl;
    logic [1:0]           hdr;
    logic [CNT_W-1:0]     cnt;
    logic [4:0]           fpos;
  } cmt_t;

  function automatic logic [7:0] tag_char(input logic [47:0] tag, input logic [2:0] p);
    tag_char = tag[8*(5-int'(p)) +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic [ACC_L_W-1:0] push_l(input logic [ACC_L_W-1:0] a,
                                               input logic [3:0] d);
    logic [ACC_L_W+3:0] t;
    t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {(ACC_L_W)'(0), d};
    push_l = (t > {4'b0, ACC_L_CAP}) ? ACC_L_CAP : t[ACC_L_W-1:0];
  endfunction

  function automatic logic [ACC_C_W-1:0] push_c(input logic [ACC_C_W-1:0] a,
                                               input logic [3:0] d);
    logic [ACC_C_W+3:0] t;
    t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {(ACC_C_W)'(0), d};
    push_c = (t > {4'b0, ACC_C_CAP}) ? ACC_C_CAP : t[ACC_C_W-1:0];
  endfunction

  // x below ten times the modulus plus ten
  function automatic logic [MOD_W-1:0] mod_push(input logic [MOD_W-1:0] m,
                                               input logic [3:0] d);
    logic [19:0] x;
    logic [19:0] r;
    x = ({4'b0, m} << 3) + ({4'b0, m} << 1) + {16'b0, d};
    r = x;
    for (int t = 1; t <= 10; t++) begin
      if (x >= 20'(t * COURSE_MOD_I)) begin
        r = x - 20'(t * COURSE_MOD_I);
      end
    end
    mod_push = r[MOD_W-1:0];
  endfunction

  function automatic logic [6:0] pair_value(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] da;
    logic [6:0] db;
    da = {3'b0, a[3:0]};
    db = {3'b0, b[3:0]};
    if (!is_digit(a)) begin
      pair_value = 7'd0;
    end else if (!is_digit(b)) begin
      pair_value = da;
    end else begin
      pair_value = (da << 3) + (da << 1) + db;
    end
  endfunction

endpackage

// ===== src/nmea_line_parser.sv =====
// per-byte line state: header match, field count, number accumulation
// depends on nmea_pkg; emits a registered field snapshot per byte
module nmea_line_parser (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    a_valid,
  input  logic [7:0]              a_byte,
  output nmea_pkg::snap_t         snap
);

  logic [nmea_pkg::CNT_W-1:0]   cnt, cnt_next;
  logic [1:0]                   hm, hm_next;
  logic [4:0]                   fpos, fpos_next;
  logic [6:0]                   cif, cif_next;
  logic [nmea_pkg::ACC_L_W-1:0] acc_l, acc_l_next;
  logic [nmea_pkg::ACC_C_W-1:0] acc_c, acc_c_next;
  logic [nmea_pkg::MOD_W-1:0]   acc_m, acc_m_next;
  logic                         neg, neg_next;
  logic                         dot, dot_next;
  logic                         stop, stop_next;
  logic [2:0]                   frac, frac_next;
  logic [5:0][7:0]              text, text_next;
  nmea_pkg::snap_t              snap_next;

  logic                         restart, take, is_comma, is_nl;
  logic [nmea_pkg::CNT_W-1:0]   cnt_e;
  logic [1:0]                   hm_e, h;
  logic [4:0]                   fpos_e;
  logic [6:0]                   f_cif;
  logic [nmea_pkg::ACC_L_W-1:0] f_acc_l;
  logic [nmea_pkg::ACC_C_W-1:0] f_acc_c;
  logic [nmea_pkg::MOD_W-1:0]   f_acc_m;
  logic                         f_neg, f_dot, f_stop;
  logic [2:0]                   f_frac;
  logic [5:0][7:0]              f_text;

  always_comb begin
    restart  = (a_byte == nmea_pkg::CH_DOLLAR);
    is_comma = (a_byte == nmea_pkg::CH_COMMA);
    is_nl    = (a_byte == nmea_pkg::CH_NL);
    cnt_e    = restart ? '0 : cnt;
    hm_e     = restart ? nmea_pkg::HDR_NONE : hm;
    fpos_e   = restart ? '0 : fpos;
    f_cif    = restart ? '0 : cif;
    f_acc_l  = restart ? '0 : acc_l;
    f_acc_c  = restart ? '0 : acc_c;
    f_acc_m  = restart ? '0 : acc_m;
    f_neg    = restart ? 1'b0 : neg;
    f_dot    = restart ? 1'b0 : dot;
    f_stop   = restart ? 1'b0 : stop;
    f_frac   = restart ? '0 : frac;
    f_text   = restart ? '0 : text;
    take     = cnt_e < nmea_pkg::CNT_W'(nmea_pkg::LINE_CAPACITY - 1);
    h        = hm_e;
    cnt_next = cnt_e;
    fpos_next = fpos_e;

    if (take) begin
      if (cnt_e < nmea_pkg::CNT_W'(6)) begin
        if (cnt_e == '0) begin
          h = nmea_pkg::HDR_BOTH;
        end
        if (a_byte != nmea_pkg::tag_char(nmea_pkg::RMC_TAG, cnt_e[2:0])) begin
          h[0] = 1'b0;
        end
        if (a_byte != nmea_pkg::tag_char(nmea_pkg::GGA_TAG, cnt_e[2:0])) begin
          h[1] = 1'b0;
        end
      end
      if (is_comma) begin
        if (fpos_e != 5'd31) begin
          fpos_next = fpos_e + 5'd1;
        end
      end else begin
        if (f_cif < 7'd6) begin
          f_text[f_cif[2:0]] = a_byte;
        end
        if (!f_stop) begin
          if (f_cif == '0 && (a_byte == nmea_pkg::CH_MINUS ||
                              a_byte == nmea_pkg::CH_PLUS)) begin
            f_neg = (a_byte == nmea_pkg::CH_MINUS);
          end else if (nmea_pkg::is_digit(a_byte)) begin
            if (!f_dot || f_frac < 3'd4) begin
              f_acc_l = nmea_pkg::push_l(f_acc_l, a_byte[3:0]);
            end
            if (!f_dot || f_frac < 3'd2) begin
              f_acc_c = nmea_pkg::push_c(f_acc_c, a_byte[3:0]);
              f_acc_m = nmea_pkg::mod_push(f_acc_m, a_byte[3:0]);
            end
            if (f_dot && f_frac < 3'd4) begin
              f_frac = f_frac + 3'd1;
            end
          end else if (a_byte == nmea_pkg::CH_DOT && !f_dot) begin
            f_dot = 1'b1;
          end else begin
            f_stop = 1'b1;
          end
        end
        if (f_cif != 7'd127) begin
          f_cif = f_cif + 7'd1;
        end
      end
      cnt_next = cnt_e + nmea_pkg::CNT_W'(1);
    end
    hm_next = h;

    if (take && is_comma) begin
      cif_next   = '0;
      acc_l_next = '0;
      acc_c_next = '0;
      acc_m_next = '0;
      neg_next   = 1'b0;
      dot_next   = 1'b0;
      stop_next  = 1'b0;
      frac_next  = '0;
      text_next  = '0;
    end else begin
      cif_next   = f_cif;
      acc_l_next = f_acc_l;
      acc_c_next = f_acc_c;
      acc_m_next = f_acc_m;
      neg_next   = f_neg;
      dot_next   = f_dot;
      stop_next  = f_stop;
      frac_next  = f_frac;
      text_next  = f_text;
    end

    snap_next.valid   = a_valid;
    snap_next.stage   = (take && is_comma) || is_nl;
    snap_next.nl      = is_nl;
    snap_next.restart = restart;
    snap_next.pos     = fpos_e;
    snap_next.fpos    = fpos_next;
    snap_next.hdr     = hm_next;
    snap_next.cnt     = cnt_next;
    snap_next.cif     = f_cif;
    snap_next.neg     = f_neg;
    snap_next.frac    = f_frac;
    snap_next.acc_l   = f_acc_l;
    snap_next.acc_c   = f_acc_c;
    snap_next.acc_m   = f_acc_m;
    snap_next.text    = f_text;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      hm    <= nmea_pkg::HDR_NONE;
      fpos  <= '0;
      cif   <= '0;
      acc_l <= '0;
      acc_c <= '0;
      acc_m <= '0;
      neg   <= 1'b0;
      dot   <= 1'b0;
      stop  <= 1'b0;
      frac  <= '0;
      text  <= '0;
      snap  <= '0;
    end else if (en) begin
      snap <= snap_next;
      if (a_valid) begin
        cnt   <= cnt_next;
        hm    <= hm_next;
        fpos  <= fpos_next;
        cif   <= cif_next;
        acc_l <= acc_l_next;
        acc_c <= acc_c_next;
        acc_m <= acc_m_next;
        neg   <= neg_next;
        dot   <= dot_next;
        stop  <= stop_next;
        frac  <= frac_next;
        text  <= text_next;
      end
    end
  end

endmodule

// ===== src/nmea_field_stage.sv =====
// converts a field snapshot to fixed point and stages it by position
// depends on nmea_pkg; feeds staged fields and line info to the commit
module nmea_field_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  nmea_pkg::snap_t snap,
  output nmea_pkg::pend_t pend,
  output nmea_pkg::cmt_t  cmt
);

  logic [13:0]           scale_l;
  logic [6:0]            scale_c;
  logic [43:0]           prod_l;
  logic [33:0]           prod_c;
  logic [26:0]           lat_mag;
  logic [29:0]           lon_mag;
  logic [23:0]           centi_mag;
  logic [nmea_pkg::MOD_W-1:0] m1, m2, cm, course;
  logic signed [27:0]    lat_v;
  logic signed [30:0]    lon_v;
  logic signed [24:0]    alt_v;
  logic [23:0]           speed_v;
  nmea_pkg::pairs_t      code;
  logic                  rmc, gga;
  nmea_pkg::pend_t       pend_next;
  nmea_pkg::cmt_t        cmt_next;

  always_comb begin
    case (snap.frac)
      3'd0:    scale_l = 14'd10000;
      3'd1:    scale_l = 14'd1000;
      3'd2:    scale_l = 14'd100;
      3'd3:    scale_l = 14'd10;
      default: scale_l = 14'd1;
    endcase
    case (snap.frac)
      3'd0:    scale_c = 7'd100;
      3'd1:    scale_c = 7'd10;
      default: scale_c = 7'd1;
    endcase
    prod_l = 44'(snap.acc_l) * 44'(scale_l);
    prod_c = 34'(snap.acc_c) * 34'(scale_c);

    lat_mag = (prod_l > 44'(nmea_pkg::LAT_CAP)) ? nmea_pkg::LAT_CAP : prod_l[26:0];
    lon_mag = (prod_l > 44'(nmea_pkg::ACC_L_CAP)) ? nmea_pkg::ACC_L_CAP : prod_l[29:0];
    lat_v = snap.neg ? -$signed({1'b0, lat_mag}) : $signed({1'b0, lat_mag});
    lon_v = snap.neg ? -$signed({1'b0, lon_mag}) : $signed({1'b0, lon_mag});

    centi_mag = (prod_c > 34'(nmea_pkg::CENTI_CAP)) ? nmea_pkg::CENTI_CAP : prod_c[23:0];
    speed_v = snap.neg ? '0 : centi_mag;
    alt_v = snap.neg ? -$signed({1'b0, centi_mag}) : $signed({1'b0, centi_mag});

    m1 = nmea_pkg::mod_push(snap.acc_m, 4'd0);
    m2 = nmea_pkg::mod_push(m1, 4'd0);
    case (snap.frac)
      3'd0:    cm = m2;
      3'd1:    cm = m1;
      default: cm = snap.acc_m;
    endcase
    if (prod_c >= 34'(nmea_pkg::ACC_C_CAP)) begin
      cm = nmea_pkg::COURSE_SAT;
    end
    course = (snap.neg && cm != '0) ? nmea_pkg::COURSE_MOD - cm : cm;

    code[0] = nmea_pkg::pair_value(snap.text[0], snap.text[1]);
    code[1] = nmea_pkg::pair_value(snap.text[2], snap.text[3]);
    code[2] = nmea_pkg::pair_value(snap.text[4], snap.text[5]);

    rmc = (snap.hdr == nmea_pkg::HDR_RMC);
    gga = (snap.hdr == nmea_pkg::HDR_GGA);

    pend_next = snap.restart ? '0 : pend;
    if (snap.stage) begin
      case (snap.pos)
        5'd1: begin
          pend_next.time_ok    = rmc && (snap.cif >= 7'd6);
          pend_next.time_pairs = rmc ? code : '0;
        end
        5'd3: pend_next.lat    = rmc ? lat_v : '0;
        5'd4: pend_next.ns     = rmc && (snap.text[0] == nmea_pkg::CH_S);
        5'd5: pend_next.lon    = rmc ? lon_v : '0;
        5'd6: pend_next.ew     = rmc && (snap.text[0] == nmea_pkg::CH_W);
        5'd7: pend_next.speed  = rmc ? speed_v : '0;
        5'd8: pend_next.course = rmc ? course : '0;
        5'd9: begin
          pend_next.date_ok    = rmc && (snap.cif == 7'd6);
          pend_next.date_pairs = rmc ? code : '0;
          pend_next.alt        = gga ? alt_v : '0;
        end
        default: ;
      endcase
    end

    cmt_next.valid = snap.valid;
    cmt_next.nl    = snap.nl;
    cmt_next.hdr   = snap.hdr;
    cmt_next.cnt   = snap.cnt;
    cmt_next.fpos  = snap.fpos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      cmt  <= '0;
    end else if (en) begin
      cmt <= cmt_next;
      if (snap.valid) begin
        pend <= pend_next;
      end
    end
  end

endmodule

// ===== src/nmea_rmc_gga_field_extractor.sv =====
// path: input register, parser snapshot, commit register, fix output register
// throughput: one byte per cycle; the pipeline holds only when a newline
// reaches the commit register while the previous result is still untaken
// reset: synchronous, clears line state, staged and held values to zero,
// length bounds to 50 and 80; no clearing pass
// top level over nmea_pkg, nmea_line_parser, nmea_field_stage, assert_macros.svh
`include "assert_macros.svh"

module nmea_rmc_gga_field_extractor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nmea_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [nmea_pkg::LEN_W-1:0]        cfg_data,
  input  logic                              byte_valid,
  output logic                              byte_ready,
  input  logic [7:0]                        rx_byte,
  output logic                              fix_valid,
  input  logic                              fix_ready,
  output logic [1:0]                        sentence_kind,
  output logic signed [27:0]                latitude_e6,
  output logic signed [30:0]                longitude_e6,
  output logic [15:0]                       course_centideg,
  output logic [23:0]                       speed_centiknots,
  output logic signed [24:0]                altitude_cm,
  output logic [6:0]                        day_of_month,
  output logic [6:0]                        month_number,
  output logic [6:0]                        year_two_digit,
  output logic [6:0]                        hour_value,
  output logic [6:0]                        minute_value,
  output logic [6:0]                        second_value
);

  logic [nmea_pkg::LEN_W-1:0] min_len, max_len;
  logic                       a_valid;
  logic [7:0]                 a_byte;
  logic                       en, emit, len_ok, commit_rmc, commit_gga;
  logic [nmea_pkg::LEN_W-1:0] line_len;
  logic [1:0]                 kind_next;
  nmea_pkg::snap_t            snap;
  nmea_pkg::pend_t            pend;
  nmea_pkg::cmt_t             cmt;

  assign cfg_ready  = 1'b1;
  assign emit       = cmt.valid && cmt.nl;
  assign en         = !(fix_valid && !fix_ready && emit);
  assign byte_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_len <= nmea_pkg::MIN_LEN_RESET;
      max_len <= nmea_pkg::MAX_LEN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == nmea_pkg::REG_MIN_LEN) begin
        min_len <= cfg_data;
      end
      if (cfg_index == nmea_pkg::REG_MAX_LEN) begin
        max_len <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      a_byte  <= '0;
    end else if (en) begin
      a_valid <= byte_valid;
      a_byte  <= rx_byte;
    end
  end

  nmea_line_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .a_valid (a_valid),
    .a_byte  (a_byte),
    .snap    (snap)
  );

  nmea_field_stage u_stage (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .snap (snap),
    .pend (pend),
    .cmt  (cmt)
  );

  always_comb begin
    line_len   = nmea_pkg::LEN_W'(cmt.cnt);
    len_ok     = line_len >= nmea_pkg::HEADER_LEN && line_len >= min_len &&
                 line_len <= max_len;
    commit_rmc = len_ok && cmt.hdr == nmea_pkg::HDR_RMC && cmt.fpos >= 5'd6;
    commit_gga = len_ok && cmt.hdr == nmea_pkg::HDR_GGA && cmt.fpos >= 5'd14;
    if (commit_rmc) begin
      kind_next = nmea_pkg::KIND_RMC;
    end else if (commit_gga) begin
      kind_next = nmea_pkg::KIND_GGA;
    end else begin
      kind_next = nmea_pkg::KIND_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_valid        <= 1'b0;
      sentence_kind    <= nmea_pkg::KIND_OTHER;
      latitude_e6      <= '0;
      longitude_e6     <= '0;
      course_centideg  <= '0;
      speed_centiknots <= '0;
      altitude_cm      <= '0;
      day_of_month     <= '0;
      month_number     <= '0;
      year_two_digit   <= '0;
      hour_value       <= '0;
      minute_value     <= '0;
      second_value     <= '0;
    end else if (en && emit) begin
      fix_valid     <= 1'b1;
      sentence_kind <= kind_next;
      if (commit_rmc) begin
        latitude_e6  <= pend.ns ? -pend.lat : pend.lat;
        longitude_e6 <= pend.ew ? -pend.lon : pend.lon;
        if (cmt.fpos >= 5'd8) begin
          course_centideg  <= pend.course;
          speed_centiknots <= pend.speed;
        end
        if (cmt.fpos >= 5'd9 && pend.time_ok && pend.date_ok) begin
          day_of_month   <= pend.date_pairs[0];
          month_number   <= pend.date_pairs[1];
          year_two_digit <= pend.date_pairs[2];
          hour_value     <= pend.time_pairs[0];
          minute_value   <= pend.time_pairs[1];
          second_value   <= pend.time_pairs[2];
        end
      end
      if (commit_gga) begin
        altitude_cm <= pend.alt;
      end
    end else if (fix_ready) begin
      fix_valid <= 1'b0;
    end
  end

  `ASSERT_NEXT(a_held_only_on_beat, !(en && emit), $stable(latitude_e6), "held value moved without a result")
  `ASSERT_NOW(a_stall_blocks_input, fix_valid && !fix_ready && emit, !byte_ready, "input taken while result blocked")
  `ASSERT_NOW(a_course_wrapped, 1'b1, course_centideg < nmea_pkg::COURSE_MOD, "course out of range")
  `ASSERT_NOW(a_kind_needs_length, commit_rmc || commit_gga, len_ok, "commit without accepted length")

endmodule

// ===== verif/nmea_rmc_gga_field_extractor_test.sv =====
// self-checking testbench for nmea_rmc_gga_field_extractor: byte stream in, one fix per newline
// depends on nmea_pkg and the rtl of the block; holds its own line parser as predictor
module nmea_rmc_gga_field_extractor_test;

  localparam int        LIMIT_CYCLES = 600000;
  localparam int        DRAIN_CYCLES = 12;
  localparam int        PHASE_BYTES  = 240;
  localparam longint    NUM_CAP      = 64'd9999999999;

  typedef struct packed {
    logic [1:0]  kind;
    logic [27:0] lat;
    logic [30:0] lon;
    logic [15:0] course;
    logic [23:0] speed;
    logic [24:0] alt;
    logic [6:0]  day;
    logic [6:0]  month;
    logic [6:0]  year;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
  } fix_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [nmea_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [nmea_pkg::LEN_W-1:0] cfg_data = '0;
  logic              byte_valid = 1'b0;
  logic              byte_ready;
  logic [7:0]        rx_byte = 8'h00;
  logic              fix_valid;
  logic              fix_ready = 1'b0;
  logic [1:0]        sentence_kind;
  logic signed [27:0] latitude_e6;
  logic signed [30:0] longitude_e6;
  logic [15:0]       course_centideg;
  logic [23:0]       speed_centiknots;
  logic signed [24:0] altitude_cm;
  logic [6:0]        day_of_month;
  logic [6:0]        month_number;
  logic [6:0]        year_two_digit;
  logic [6:0]        hour_value;
  logic [6:0]        minute_value;
  logic [6:0]        second_value;

  nmea_rmc_gga_field_extractor u_top (.*);

  always #5 clk = ~clk;

  // predictor state
  int unsigned line_min = 50, line_max = 80;
  int unsigned line_cnt, hdr, fpos, cif, frac;
  longint      num_acc;
  bit          num_neg, num_dot, num_stop;
  logic [7:0]  ftext [6];
  longint      staged [9];
  longint      held [11];
  int          last_kind;

  fix_t        fix_q [$];
  int          errors, bytes_in, fixes_out, rmc_commits, gga_commits, cycles;
  int          burst_left, hold_left, mode, mode_left;
  bit          hold_done;

  function automatic longint num_push(longint a, int d);
    if (a > (NUM_CAP - d) / 10) return NUM_CAP;
    return a * 10 + d;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic bit digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic longint digit_pair(logic [7:0] a, logic [7:0] b);
    if (!digit(a)) return 0;
    if (!digit(b)) return a - "0";
    return (a - "0") * 10 + (b - "0");
  endfunction

  function automatic longint pairs_code(bit ok);
    return (longint'(ok) << 21) | (digit_pair(ftext[0], ftext[1]) << 14) |
           (digit_pair(ftext[2], ftext[3]) << 7) | digit_pair(ftext[4], ftext[5]);
  endfunction

  task automatic new_field();
    cif = 0; num_acc = 0; num_neg = 0; num_dot = 0; num_stop = 0; frac = 0;
    for (int i = 0; i < 6; i++) ftext[i] = 8'h00;
  endtask

  task automatic new_line();
    line_cnt = 0; hdr = nmea_pkg::HDR_NONE; fpos = 0;
    new_field();
    for (int i = 0; i < 9; i++) staged[i] = 0;
  endtask

  task automatic stage_current();
    longint m, v, r;
    r = 0;
    if (fpos < 1 || fpos > 9) return;
    m = num_acc;
    for (int f = frac; f < 4; f++) m = num_push(m, 0);
    v = num_neg ? -m : m;
    if (hdr == nmea_pkg::HDR_RMC) begin
      case (fpos)
        1: r = pairs_code(cif >= 6);
        3: r = clip(v, -99999999, 99999999);
        4: r = ftext[0] == nmea_pkg::CH_S;
        5: r = clip(v, -999999999, 999999999);
        6: r = ftext[0] == nmea_pkg::CH_W;
        7: r = clip(v / 100, 0, 9999999);
        8: begin
          r = (v / 100) % 36000;
          if (r < 0) r += 36000;
        end
        9: r = pairs_code(cif == 6);
        default: r = 0;
      endcase
    end else if (hdr == nmea_pkg::HDR_GGA && fpos == 9) begin
      r = clip(v / 100, -9999999, 9999999);
    end
    staged[fpos - 1] = r;
  endtask

  task automatic store_char(logic [7:0] c);
    if (line_cnt < 6) begin
      if (line_cnt == 0) hdr = nmea_pkg::HDR_BOTH;
      if (c != nmea_pkg::RMC_TAG[8*(5-line_cnt) +: 8]) hdr &= ~nmea_pkg::HDR_RMC;
      if (c != nmea_pkg::GGA_TAG[8*(5-line_cnt) +: 8]) hdr &= ~nmea_pkg::HDR_GGA;
    end
    if (c == nmea_pkg::CH_COMMA) begin
      stage_current();
      if (fpos < 31) fpos++;
      new_field();
    end else begin
      if (cif < 6) ftext[cif] = c;
      if (!num_stop) begin
        if (cif == 0 && (c == nmea_pkg::CH_MINUS || c == nmea_pkg::CH_PLUS))
          num_neg = c == nmea_pkg::CH_MINUS;
        else if (digit(c)) begin
          if (!num_dot) num_acc = num_push(num_acc, c - "0");
          else if (frac < 4) begin
            num_acc = num_push(num_acc, c - "0");
            frac++;
          end
        end else if (c == nmea_pkg::CH_DOT && !num_dot) num_dot = 1;
        else num_stop = 1;
      end
      if (cif < 127) cif++;
    end
    line_cnt++;
  endtask

  function automatic int commit_kind();
    int unsigned nf;
    nf = fpos + 1;
    if (!(line_cnt >= 6 && line_cnt >= line_min && line_cnt <= line_max))
      return nmea_pkg::KIND_OTHER;
    if (hdr == nmea_pkg::HDR_RMC && nf >= 7) begin
      held[0] = staged[3] ? -staged[2] : staged[2];
      held[1] = staged[5] ? -staged[4] : staged[4];
      if (nf >= 9) begin
        held[2] = staged[7];
        held[3] = staged[6];
      end
      if (nf >= 10 && staged[0][21] && staged[8][21]) begin
        held[5]  = (staged[8] >> 14) & 127;
        held[6]  = (staged[8] >> 7) & 127;
        held[7]  = staged[8] & 127;
        held[8]  = (staged[0] >> 14) & 127;
        held[9]  = (staged[0] >> 7) & 127;
        held[10] = staged[0] & 127;
      end
      return nmea_pkg::KIND_RMC;
    end
    if (hdr == nmea_pkg::HDR_GGA && nf >= 15) begin
      held[4] = staged[8];
      return nmea_pkg::KIND_GGA;
    end
    return nmea_pkg::KIND_OTHER;
  endfunction

  task automatic predict_byte(logic [7:0] c);
    fix_t f;
    bytes_in++;
    if (c == nmea_pkg::CH_DOLLAR) new_line();
    if (line_cnt + 1 < nmea_pkg::LINE_CAPACITY) store_char(c);
    if (c != nmea_pkg::CH_NL) return;
    stage_current();
    last_kind = commit_kind();
    if (last_kind == nmea_pkg::KIND_RMC) rmc_commits++;
    if (last_kind == nmea_pkg::KIND_GGA) gga_commits++;
    f.kind = last_kind[1:0];
    f.lat = held[0][27:0];     f.lon = held[1][30:0];
    f.course = held[2][15:0];  f.speed = held[3][23:0];
    f.alt = held[4][24:0];     f.day = held[5][6:0];
    f.month = held[6][6:0];    f.year = held[7][6:0];
    f.hour = held[8][6:0];     f.minute = held[9][6:0];
    f.second = held[10][6:0];
    fix_q.push_back(f);
  endtask

  task automatic report(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
    errors++;
  endtask

  // sampling at the falling edge, where everything for the coming edge is settled
  always @(negedge clk) begin
    fix_t w;
    if (!rst && byte_valid && byte_ready) predict_byte(rx_byte);
    if (!rst && cfg_valid && cfg_ready) begin
      if (cfg_index == nmea_pkg::REG_MIN_LEN) line_min = cfg_data;
      else line_max = cfg_data;
    end
    if (!rst && fix_valid && fix_ready) begin
      fixes_out++;
      if (fix_q.size() == 0) report("unexpected fix beat", sentence_kind, 0);
      else begin
        w = fix_q.pop_front();
        if (sentence_kind != w.kind) report("sentence_kind", sentence_kind, w.kind);
        if (latitude_e6 != w.lat) report("latitude_e6", latitude_e6, w.lat);
        if (longitude_e6 != w.lon) report("longitude_e6", longitude_e6, w.lon);
        if (course_centideg != w.course) report("course_centideg", course_centideg, w.course);
        if (speed_centiknots != w.speed) report("speed_centiknots", speed_centiknots, w.speed);
        if (altitude_cm != w.alt) report("altitude_cm", altitude_cm, w.alt);
        if (day_of_month != w.day) report("day_of_month", day_of_month, w.day);
        if (month_number != w.month) report("month_number", month_number, w.month);
        if (year_two_digit != w.year) report("year_two_digit", year_two_digit, w.year);
        if (hour_value != w.hour) report("hour_value", hour_value, w.hour);
        if (minute_value != w.minute) report("minute_value", minute_value, w.minute);
        if (second_value != w.second) report("second_value", second_value, w.second);
      end
    end
  end

  // fix receiver: stall patterns plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      fix_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      fix_ready <= 1'b0;
    end else if (!hold_done && bytes_in > 700) begin
      hold_done = 1;
      hold_left = 500;
      fix_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode = $urandom_range(0, 2);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      fix_ready <= mode == 0 ? 1'b1 : mode == 1 ? ($urandom_range(0, 3) != 0)
                                                : 1'($urandom_range(0, 1));
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("** nmea_rmc_gga_field_extractor: FAILED **");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(60, 200) : $urandom_range(1, 20);
    end
    burst_left--;
    byte_valid <= 1'b1;
    rx_byte <= b;
    do @(negedge clk); while (!byte_ready);
    @(posedge clk);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic settle();
    byte_valid <= 1'b0;
    while (fix_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(logic [nmea_pkg::CFG_INDEX_W-1:0] idx, int unsigned v);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[nmea_pkg::LEN_W-1:0];
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic string digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    return s;
  endfunction

  function automatic string rand_number(int int_max);
    string s;
    int r;
    s = "";
    r = $urandom_range(0, 7);
    if (r == 0) s = "-";
    else if (r == 1) s = "+";
    s = {s, digits($urandom_range(0, 9) == 0 ? 11 : $urandom_range(0, int_max))};
    if ($urandom_range(0, 4) != 0) s = {s, ".", digits($urandom_range(0, 6))};
    if ($urandom_range(0, 12) == 0) s = {s, "x", digits(2)};
    return s;
  endfunction

  function automatic string pair_text(int n);
    string s;
    s = digits(n);
    if ($urandom_range(0, 9) == 0 && n > 0) s[$urandom_range(0, n - 1)] = "A";
    return s;
  endfunction

  function automatic string sentence(bit gga);
    string f [$];
    string s;
    int keep;
    if (!gga) begin
      f = '{"$GPRMC", {pair_text($urandom_range(0, 5) == 0 ? $urandom_range(3, 5) : 6),
            $urandom_range(0, 1) ? ".00" : ""}, "A", rand_number(4),
            $urandom_range(0, 1) ? "S" : "N", rand_number(5), $urandom_range(0, 1) ? "W" : "E",
            rand_number(3), rand_number(4),
            pair_text($urandom_range(0, 5) == 0 ? $urandom_range(4, 7) : 6), "", "A*3C"};
    end else begin
      f = '{"$GPGGA", digits(6), rand_number(4), "N", rand_number(5), "E", "1", "08", "0.9",
            rand_number(5), "M", rand_number(2), "M", "", "*47"};
    end
    keep = $urandom_range(0, 3) == 0 ? $urandom_range(1, f.size()) : f.size();
    s = f[0];
    for (int i = 1; i < keep; i++) s = {s, ",", f[i]};
    return s;
  endfunction

  function automatic string noise();
    string s;
    int n;
    n = $urandom_range(1, 20);
    s = "";
    for (int i = 0; i < n; i++) begin
      s = {s, " "};
      s[i] = $urandom_range(0, 4) == 0 ? nmea_pkg::CH_NL : 8'($urandom_range(1, 255));
    end
    return s;
  endfunction

  task automatic random_phase(int unsigned lo, int unsigned hi);
    string s;
    int r, start, cut;
    write_len(nmea_pkg::REG_MIN_LEN, lo);
    write_len(nmea_pkg::REG_MAX_LEN, hi);
    start = bytes_in;
    while (bytes_in - start < PHASE_BYTES) begin
      r = $urandom_range(0, 19);
      if (r < 14) begin
        s = sentence(r >= 9);
        if ($urandom_range(0, 9) == 0) s[$urandom_range(1, s.len() - 1)] = 8'($urandom_range(0, 255));
        send_text({s, "\n"});
      end else if (r < 17) begin
        send_text(noise());
      end else if (r < 19) begin
        s = sentence(r == 18);
        cut = $urandom_range(1, s.len());
        send_text(s.substr(0, cut - 1));
        if ($urandom_range(0, 1)) send_text("\n");
      end else begin
        send_text({"$GPRMC,", digits(130), "\n"});
      end
      // an extra byte, either 0x00 or 0xff
      if ($urandom_range(0, 5) == 0) send_byte($urandom_range(0, 1) ? 8'h00 : 8'hFF);
    end
  endtask

  string dir_text [10];
  int    dir_reps [10];
  int    dir_kind [10];

  initial begin
    new_line();
    for (int i = 0; i < 11; i++) held[i] = 0;
    dir_text[0] = "\n";                                  dir_kind[0] = nmea_pkg::KIND_OTHER;
    dir_text[1] = "$GPRMC,123519.00,A,4807.0380,N,01131.0000,E,022.4,084.4,230394,003.1,W*6A\n";
    dir_kind[1] = nmea_pkg::KIND_RMC;
    dir_text[2] = "$GPRMC,235959,A,99999.99999,S,999999.9999,W,99999999999,-12.5,311299,,*0\n";
    dir_kind[2] = nmea_pkg::KIND_RMC;
    dir_text[3] = "$GPRMC,000000,V,0.0,N,-0.0,E,0,72000.00,01019,,*00\n";
    dir_kind[3] = nmea_pkg::KIND_RMC;
    dir_text[4] = "$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,-545.4,M,46.9,M,,*47\n";
    dir_kind[4] = nmea_pkg::KIND_GGA;
    dir_text[5] = "$GPGGA,1,2,3,4,5,6,7,8,99999999999.999,M,4,M,5,*47\n";
    dir_kind[5] = nmea_pkg::KIND_GGA;
    dir_text[6] = "$GPRMC,1,2\n";                        dir_kind[6] = nmea_pkg::KIND_OTHER;
    dir_text[7] = "0123456789";  dir_reps[7] = 14;       dir_kind[7] = -1;
    dir_text[8] = "\n";                                  dir_kind[8] = nmea_pkg::KIND_OTHER;
    dir_text[9] = "4,5\n";                               dir_kind[9] = -1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int r = 0; r < 10; r++) begin
      if (r == 7) send_text("$GPRMC,4807");
      for (int k = 0; k < (dir_reps[r] > 0 ? dir_reps[r] : 1); k++) send_text(dir_text[r]);
      if (dir_kind[r] >= 0 && last_kind != dir_kind[r]) report("directed kind", last_kind, dir_kind[r]);
    end
    random_phase(50, 80);
    random_phase(0, 1023);
    random_phase(1023, 0);
    random_phase(6, 127);
    random_phase(40, 70);
    settle();
    $display("%0d bytes in, %0d fixes out, %0d rmc and %0d gga commits over five length windows",
             bytes_in, fixes_out, rmc_commits, gga_commits);
    if (errors == 0) begin
      $display("** nmea_rmc_gga_field_extractor: PASSED **");
    end else begin
      $display("%0d mismatches", errors);
      $display("** nmea_rmc_gga_field_extractor: FAILED **");
    end
    $finish;
  end

endmodule
